[src/gaps_pkg.sv]
`timescale 1ns / 1ps

package gaps_pkg;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 8;
    localparam int NCELLS    = GRID_ROWS * GRID_COLS;
    localparam int CELL_W    = $clog2(NCELLS);
    localparam int CNT_W     = $clog2(NCELLS + 1);
    localparam int COST_W    = 16;
    localparam int F_W       = COST_W + 1;
    localparam int DIST_W    = 12;
    localparam int STEP_W    = 9;
    localparam int MAX_OUT   = 64;
    localparam int OUT_CNT_W = $clog2(MAX_OUT);

    localparam logic [STEP_W-1:0] STEP_ORTHO = 9'd256;
    localparam logic [STEP_W-1:0] STEP_DIAG  = 9'd362;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [2:0] row;
        logic [2:0] col;
        logic       blocked;
        logic [2:0] goal_row;
        logic [2:0] goal_col;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] path_row;
        logic [2:0] path_col;
        logic       found;
        logic       last;
    } res_item_t;

    // write and read controls of the node store
    typedef struct packed {
        logic              order_we;
        logic [CELL_W-1:0] order_waddr;
        logic [CELL_W-1:0] order_wdata;
        logic [CELL_W-1:0] order_raddr;
        logic              cost_we;
        logic [CELL_W-1:0] cost_waddr;
        logic [COST_W-1:0] cost_wdata;
        logic [CELL_W-1:0] cost_raddr;
        logic              par_we;
        logic [CELL_W-1:0] par_waddr;
        logic [CELL_W-1:0] par_wdata;
        logic [CELL_W-1:0] par_raddr;
    } gaps_mem_req_t;

    // round(256 * sqrt(dr*dr + dc*dc))
    function automatic logic [DIST_W-1:0] dist_fx(input logic [2:0] dr, input logic [2:0] dc);
        logic [6:0] n;
        logic [DIST_W-1:0] d;
        n = 7'({4'b0, dr} * {4'b0, dr}) + 7'({4'b0, dc} * {4'b0, dc});
        case (n)
            7'd0:  d = 12'd0;
            7'd1:  d = 12'd256;
            7'd2:  d = 12'd362;
            7'd4:  d = 12'd512;
            7'd5:  d = 12'd572;
            7'd8:  d = 12'd724;
            7'd9:  d = 12'd768;
            7'd10: d = 12'd810;
            7'd13: d = 12'd923;
            7'd16: d = 12'd1024;
            7'd17: d = 12'd1056;
            7'd18: d = 12'd1086;
            7'd20: d = 12'd1145;
            7'd25: d = 12'd1280;
            7'd26: d = 12'd1305;
            7'd29: d = 12'd1379;
            7'd32: d = 12'd1448;
            7'd34: d = 12'd1493;
            7'd36: d = 12'd1536;
            7'd37: d = 12'd1557;
            7'd40: d = 12'd1619;
            7'd41: d = 12'd1639;
            7'd45: d = 12'd1717;
            7'd49: d = 12'd1792;
            7'd50: d = 12'd1810;
            7'd52: d = 12'd1846;
            7'd53: d = 12'd1864;
            7'd58: d = 12'd1950;
            7'd61: d = 12'd1999;
            7'd64: d = 12'd2048;
            7'd65: d = 12'd2064;
            7'd68: d = 12'd2111;
            7'd72: d = 12'd2172;
            7'd74: d = 12'd2202;
            7'd85: d = 12'd2360;
            7'd98: d = 12'd2534;
            default: d = 12'd0;
        endcase
        return d;
    endfunction

endpackage

[src/gaps_node_store.sv]
`timescale 1ns / 1ps

module gaps_node_store
    import gaps_pkg::*;
(
    input  logic              clk,
    input  gaps_mem_req_t     req,
    output logic [CELL_W-1:0] order_rdata,
    output logic [COST_W-1:0] cost_rdata,
    output logic [CELL_W-1:0] par_rdata
);

    logic [CELL_W-1:0] order_mem [NCELLS];
    logic [COST_W-1:0] cost_mem  [NCELLS];
    logic [CELL_W-1:0] par_mem   [NCELLS];

    // open list in insertion order
    always_ff @(posedge clk)
    begin
        if (req.order_we)
        begin
            order_mem[req.order_waddr] <= req.order_wdata;
        end
        order_rdata <= order_mem[req.order_raddr];
    end

    // g cost per cell
    always_ff @(posedge clk)
    begin
        if (req.cost_we)
        begin
            cost_mem[req.cost_waddr] <= req.cost_wdata;
        end
        cost_rdata <= cost_mem[req.cost_raddr];
    end

    // parent per cell
    always_ff @(posedge clk)
    begin
        if (req.par_we)
        begin
            par_mem[req.par_waddr] <= req.par_wdata;
        end
        par_rdata <= par_mem[req.par_raddr];
    end

endmodule

[src/grid_astar_path_search.sv]
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid, cmd_stall | cmd_item_t: load cell or search
// res     | out       | res_valid, res_stall | res_item_t: path cell, goal first
//
// a load item writes the blocked map and the block stays idle; a search holds cmd_stall high until its last item leaves
// a search scans the open list through the order and cost memories for each expansion,
// then visits each neighbor, then walks the parent chain to send the path items
// reset clears the blocked map and all control state; node memories need no reset
// res_stall holds the output register; no new command is taken while results are pending

module grid_astar_path_search
    import gaps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_NB,
        S_NB_CMP,
        S_NB_END,
        S_OUT,
        S_PWAIT
    } state_t;

    state_t              state_reg;
    logic [NCELLS-1:0]   blocked_reg;
    logic [NCELLS-1:0]   closed_reg;
    logic [NCELLS-1:0]   open_reg;     // cell has been appended this search
    logic [CNT_W-1:0]    app_cnt_reg;  // entries appended to the open list
    logic [CNT_W-1:0]    live_cnt_reg; // appended and not yet closed
    logic [CELL_W-1:0]   start_reg;
    logic [CELL_W-1:0]   goal_reg;

    // scan pipeline
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                s1_vld_reg;
    logic                s2_vld_reg;
    logic [CELL_W-1:0]   s2_cell_reg;
    logic                s2_live_reg;
    logic                best_found_reg;
    logic [F_W-1:0]      best_f_reg;
    logic [CELL_W-1:0]   best_cell_reg;
    logic [COST_W-1:0]   best_g_reg;

    // neighbor walk
    logic [1:0]          dir_r_reg;
    logic [1:0]          dir_c_reg;

    // output
    logic                out_valid_reg;
    res_item_t           res_reg;
    logic [CELL_W-1:0]   out_cell_reg;
    logic [OUT_CNT_W-1:0] out_k_reg;

    gaps_mem_req_t       mreq;
    logic [CELL_W-1:0]   order_rdata;
    logic [COST_W-1:0]   cost_rdata;
    logic [CELL_W-1:0]   par_rdata;

    gaps_node_store u_store (
        .clk         (clk),
        .req         (mreq),
        .order_rdata (order_rdata),
        .cost_rdata  (cost_rdata),
        .par_rdata   (par_rdata)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    logic cmd_take;
    logic res_take;
    assign cmd_take = cmd_valid && !cmd_stall;
    assign res_take = out_valid_reg && !res_stall;

    // command cell indexes
    logic              cmd_in_grid;
    logic              goal_in_grid;
    logic [CELL_W-1:0] cmd_cell;
    logic [CELL_W-1:0] cmd_goal;
    assign cmd_in_grid  = (int'(cmd.row) < GRID_ROWS) && (int'(cmd.col) < GRID_COLS);
    assign goal_in_grid = (int'(cmd.goal_row) < GRID_ROWS) && (int'(cmd.goal_col) < GRID_COLS);
    assign cmd_cell = CELL_W'(int'(cmd.row) * GRID_COLS + int'(cmd.col));
    assign cmd_goal = CELL_W'(int'(cmd.goal_row) * GRID_COLS + int'(cmd.goal_col));

    // heuristic for the cell leaving the cost memory
    logic [2:0]        s2_row;
    logic [2:0]        s2_col;
    logic [2:0]        goal_row;
    logic [2:0]        goal_col;
    logic [2:0]        h_dr;
    logic [2:0]        h_dc;
    logic [F_W-1:0]    s2_f;
    assign s2_row   = 3'(s2_cell_reg / GRID_COLS);
    assign s2_col   = 3'(s2_cell_reg % GRID_COLS);
    assign goal_row = 3'(goal_reg / GRID_COLS);
    assign goal_col = 3'(goal_reg % GRID_COLS);
    assign h_dr = (s2_row > goal_row) ? s2_row - goal_row : goal_row - s2_row;
    assign h_dc = (s2_col > goal_col) ? s2_col - goal_col : goal_col - s2_col;
    assign s2_f = {1'b0, cost_rdata} + F_W'(dist_fx(h_dr, h_dc));

    // neighbor of the expanded cell, offsets carried as +1 so no negatives appear
    logic [4:0]        nr_p1;
    logic [4:0]        nc_p1;
    logic              nb_in_grid;
    logic              nb_center;
    logic              nb_diag;
    logic [CELL_W-1:0] nb_cell;
    logic              nb_ok;
    logic [F_W-1:0]    ng_sum;
    logic [COST_W-1:0] ng;
    logic              dir_last;
    assign nr_p1 = 5'(best_cell_reg / GRID_COLS) + {3'b0, dir_r_reg};
    assign nc_p1 = 5'(best_cell_reg % GRID_COLS) + {3'b0, dir_c_reg};
    assign nb_in_grid = (nr_p1 != 5'd0) && (int'(nr_p1) <= GRID_ROWS)
                     && (nc_p1 != 5'd0) && (int'(nc_p1) <= GRID_COLS);
    assign nb_center = (dir_r_reg == 2'd1) && (dir_c_reg == 2'd1);
    assign nb_diag   = (dir_r_reg != 2'd1) && (dir_c_reg != 2'd1);
    assign nb_cell = CELL_W'((int'(nr_p1) - 1) * GRID_COLS + int'(nc_p1) - 1);
    assign nb_ok = nb_in_grid && !nb_center && !closed_reg[nb_cell] && !blocked_reg[nb_cell];
    assign ng_sum = {1'b0, best_g_reg} + F_W'(nb_diag ? STEP_DIAG : STEP_ORTHO);
    assign ng = ng_sum[F_W-1] ? {COST_W{1'b1}} : ng_sum[COST_W-1:0];
    assign dir_last = (dir_r_reg == 2'd2) && (dir_c_reg == 2'd2);

    logic out_end;
    assign out_end = (out_cell_reg == start_reg) || (out_k_reg == OUT_CNT_W'(MAX_OUT - 1));

    // memory requests
    always_comb
    begin
        mreq = '0;
        mreq.order_raddr = scan_idx_reg[CELL_W-1:0];
        mreq.cost_raddr  = order_rdata;
        mreq.par_raddr   = out_cell_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take && cmd.operation == OP_SEARCH && cmd_in_grid && goal_in_grid)
                begin
                    mreq.order_we    = 1'b1;
                    mreq.order_waddr = '0;
                    mreq.order_wdata = cmd_cell;
                    mreq.cost_we     = 1'b1;
                    mreq.cost_waddr  = cmd_cell;
                    mreq.cost_wdata  = '0;
                    mreq.par_we      = 1'b1;
                    mreq.par_waddr   = cmd_cell;
                    mreq.par_wdata   = cmd_cell;
                end
            end
            S_NB:
            begin
                mreq.cost_raddr = nb_cell;
                if (nb_ok && !open_reg[nb_cell])
                begin
                    mreq.order_we    = 1'b1;
                    mreq.order_waddr = app_cnt_reg[CELL_W-1:0];
                    mreq.order_wdata = nb_cell;
                    mreq.cost_we     = 1'b1;
                    mreq.cost_waddr  = nb_cell;
                    mreq.cost_wdata  = ng;
                    mreq.par_we      = 1'b1;
                    mreq.par_waddr   = nb_cell;
                    mreq.par_wdata   = best_cell_reg;
                end
            end
            S_NB_CMP:
            begin
                // update in place only on a strictly better g
                if (ng < cost_rdata)
                begin
                    mreq.cost_we    = 1'b1;
                    mreq.cost_waddr = nb_cell;
                    mreq.cost_wdata = ng;
                    mreq.par_we     = 1'b1;
                    mreq.par_waddr  = nb_cell;
                    mreq.par_wdata  = best_cell_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            blocked_reg    <= '0;
            closed_reg     <= '0;
            open_reg       <= '0;
            app_cnt_reg    <= '0;
            live_cnt_reg   <= '0;
            scan_idx_reg   <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            dir_r_reg      <= '0;
            dir_c_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_k_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (cmd.operation == OP_LOAD)
                        begin
                            if (cmd_in_grid)
                            begin
                                blocked_reg[cmd_cell] <= cmd.blocked;
                            end
                        end
                        else if (cmd_in_grid && goal_in_grid)
                        begin
                            start_reg      <= cmd_cell;
                            goal_reg       <= cmd_goal;
                            closed_reg     <= '0;
                            open_reg       <= NCELLS'(1) << cmd_cell;
                            app_cnt_reg    <= CNT_W'(1);
                            live_cnt_reg   <= CNT_W'(1);
                            scan_idx_reg   <= '0;
                            s1_vld_reg     <= 1'b0;
                            s2_vld_reg     <= 1'b0;
                            best_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                        else
                        begin
                            // start or goal off the grid: no path
                            res_reg       <= '{path_row: '0, path_col: '0, found: 1'b0,
                                               last: 1'b1};
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                    end
                end
                S_SCAN:
                begin
                    // issue order reads, then cost reads, then compare f
                    if (scan_idx_reg != app_cnt_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                        s1_vld_reg   <= 1'b1;
                    end
                    else
                    begin
                        s1_vld_reg <= 1'b0;
                    end
                    s2_vld_reg  <= s1_vld_reg;
                    s2_cell_reg <= order_rdata;
                    s2_live_reg <= !closed_reg[order_rdata];
                    if (s2_vld_reg && s2_live_reg && (!best_found_reg || s2_f < best_f_reg))
                    begin
                        best_found_reg <= 1'b1;
                        best_f_reg     <= s2_f;
                        best_cell_reg  <= s2_cell_reg;
                        best_g_reg     <= cost_rdata;
                    end
                    if (scan_idx_reg == app_cnt_reg && !s1_vld_reg && !s2_vld_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    closed_reg[best_cell_reg] <= 1'b1;
                    live_cnt_reg <= live_cnt_reg - CNT_W'(1);
                    if (best_cell_reg == goal_reg)
                    begin
                        out_cell_reg  <= best_cell_reg;
                        out_k_reg     <= '0;
                        res_reg       <= '{path_row: 3'(best_cell_reg / GRID_COLS),
                                           path_col: 3'(best_cell_reg % GRID_COLS),
                                           found: 1'b1,
                                           last: (best_cell_reg == start_reg)};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        dir_r_reg <= '0;
                        dir_c_reg <= '0;
                        state_reg <= S_NB;
                    end
                end
                S_NB, S_NB_CMP:
                begin
                    if (state_reg == S_NB && nb_ok && open_reg[nb_cell])
                    begin
                        // already open: read its g first
                        state_reg <= S_NB_CMP;
                    end
                    else
                    begin
                        if (state_reg == S_NB && nb_ok)
                        begin
                            open_reg[nb_cell] <= 1'b1;
                            app_cnt_reg  <= app_cnt_reg + CNT_W'(1);
                            live_cnt_reg <= live_cnt_reg + CNT_W'(1);
                        end
                        if (dir_last)
                        begin
                            state_reg <= S_NB_END;
                        end
                        else
                        begin
                            state_reg <= S_NB;
                            if (dir_c_reg == 2'd2)
                            begin
                                dir_c_reg <= '0;
                                dir_r_reg <= dir_r_reg + 2'd1;
                            end
                            else
                            begin
                                dir_c_reg <= dir_c_reg + 2'd1;
                            end
                        end
                    end
                end
                S_NB_END:
                begin
                    if (live_cnt_reg != '0)
                    begin
                        scan_idx_reg   <= '0;
                        s1_vld_reg     <= 1'b0;
                        s2_vld_reg     <= 1'b0;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                    else
                    begin
                        res_reg       <= '{path_row: '0, path_col: '0, found: 1'b0,
                                           last: 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (res_take)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= res_reg.last ? S_IDLE : S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    // parent read issued in the last output cycle
                    out_cell_reg  <= par_rdata;
                    out_k_reg     <= out_k_reg + OUT_CNT_W'(1);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                    res_reg       <= '{path_row: 3'(par_rdata / GRID_COLS),
                                       path_col: 3'(par_rdata % GRID_COLS),
                                       found: 1'b1,
                                       last: (par_rdata == start_reg)
                                          || (out_k_reg == OUT_CNT_W'(MAX_OUT - 2))};
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a pending result always blocks new commands
    a_res_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("result pending while commands are taken");

    // live open entries never exceed appended entries
    a_live_le_app: assert property (@(posedge clk) disable iff (!rst_n)
        live_cnt_reg <= app_cnt_reg)
        else $error("open live count above append count");

    // the last flag of a path item matches the walk position
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (res.last == out_end))
        else $error("last flag mismatch on path item");

    // taking the final item releases the block next cycle
    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res.last) |=> (!res_valid && !cmd_stall))
        else $error("block not idle after final item");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// scoreboard for path items: queue of expected path cells, checked in order
class path_scoreboard;
    gaps_pkg::res_item_t pending_cells[$];
    int                  mismatches;
    int                  checked;

    function void note_expected(gaps_pkg::res_item_t item);
        pending_cells = {pending_cells, item};
    endfunction

    function void check_result(gaps_pkg::res_item_t got);
        gaps_pkg::res_item_t want;
        checked++;
        if (pending_cells.size() == 0)
        begin
            report_mismatch($sformatf("unexpected item row=%0d col=%0d found=%0d last=%0d",
                got.path_row, got.path_col, got.found, got.last));
        end
        else
        begin
            want = pending_cells.pop_front();
            if (got.path_row !== want.path_row)
                report_mismatch($sformatf("path_row got %0d want %0d",
                    got.path_row, want.path_row));
            if (got.path_col !== want.path_col)
                report_mismatch($sformatf("path_col got %0d want %0d",
                    got.path_col, want.path_col));
            if (got.found !== want.found)
                report_mismatch($sformatf("found got %0d want %0d", got.found, want.found));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
        end
    endfunction

    function void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
endclass

module testbench;
    import gaps_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    path_scoreboard sb = new();

    // predictor copy of the grid
    bit             blk_map[NCELLS];
    int unsigned    g_cost[NCELLS];
    int unsigned    parent_of[NCELLS];
    bit             closed_of[NCELLS];
    int unsigned    open_list[$];

    int  idle_cycles = 0;
    int  searches_sent;
    int  loads_sent;
    bit  rx_idle_off;

    always #5 clk = ~clk;

    grid_astar_path_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // euclidean distance in 8.8 fixed point, rounded to nearest
    function automatic int unsigned euclid_fx(int unsigned dr, int unsigned dc);
        int unsigned x;
        int unsigned n;
        int unsigned t;
        x = (dr * dr + dc * dc) << 16;
        n = 0;
        for (int b = 11; b >= 0; b--)
        begin
            t = n | (32'd1 << b);
            if (t * t <= x)
                n = t;
        end
        if (x > n * n + n)
            n++;
        return n;
    endfunction

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void push_cell(int unsigned cell_idx, bit found_bit, bit last_bit);
        res_item_t e;
        e.path_row = found_bit ? 3'(cell_idx / GRID_COLS) : 3'd0;
        e.path_col = found_bit ? 3'(cell_idx % GRID_COLS) : 3'd0;
        e.found    = found_bit;
        e.last     = last_bit;
        sb.note_expected(e);
    endfunction

    // a* prediction: earliest minimum f, 8 neighbors in row-major offset order
    function automatic void predict_search(cmd_item_t c);
        int unsigned start_cell, goal_cell, cur, walk_cell, nb, ng, bf, f;
        int best, pos, nr, nc;
        start_cell = c.row * GRID_COLS + c.col;
        goal_cell  = c.goal_row * GRID_COLS + c.goal_col;
        foreach (closed_of[i])
            closed_of[i] = 1'b0;
        g_cost[start_cell]    = 0;
        parent_of[start_cell] = start_cell;
        open_list = '{start_cell};
        while (open_list.size() > 0)
        begin
            best = 0;
            bf = g_cost[open_list[0]] + euclid_fx(abs_diff(open_list[0] / GRID_COLS,
                c.goal_row), abs_diff(open_list[0] % GRID_COLS, c.goal_col));
            for (int i = 1; i < open_list.size(); i++)
            begin
                f = g_cost[open_list[i]] + euclid_fx(abs_diff(open_list[i] / GRID_COLS,
                    c.goal_row), abs_diff(open_list[i] % GRID_COLS, c.goal_col));
                if (f < bf)
                begin
                    bf = f;
                    best = i;
                end
            end
            cur = open_list[best];
            open_list.delete(best);
            closed_of[cur] = 1'b1;
            if (cur == goal_cell)
            begin
                // path walk back from goal, capped at MAX_OUT items
                walk_cell = goal_cell;
                for (int k = 0; k < MAX_OUT; k++)
                begin
                    if (walk_cell == start_cell || k == MAX_OUT - 1)
                    begin
                        push_cell(walk_cell, 1'b1, 1'b1);
                        return;
                    end
                    push_cell(walk_cell, 1'b1, 1'b0);
                    walk_cell = parent_of[walk_cell];
                end
            end
            for (int di = -1; di <= 1; di++)
            begin
                for (int dj = -1; dj <= 1; dj++)
                begin
                    nr = int'(cur / GRID_COLS) + di;
                    nc = int'(cur % GRID_COLS) + dj;
                    if (di == 0 && dj == 0)
                        continue;
                    if (nr < 0 || nr >= GRID_ROWS || nc < 0 || nc >= GRID_COLS)
                        continue;
                    nb = nr * GRID_COLS + nc;
                    if (closed_of[nb] || blk_map[nb])
                        continue;
                    ng = g_cost[cur] + euclid_fx(di != 0, dj != 0);
                    if (ng > 16'hFFFF)
                        ng = 16'hFFFF;
                    pos = -1;
                    foreach (open_list[i])
                        if (open_list[i] == nb && pos < 0)
                            pos = i;
                    if (pos < 0)
                    begin
                        parent_of[nb] = cur;
                        g_cost[nb]    = ng;
                        open_list = {open_list, nb};
                    end
                    else if (ng < g_cost[nb])
                    begin
                        parent_of[nb] = cur;
                        g_cost[nb]    = ng;
                    end
                end
            end
        end
        // open list exhausted: no path
        push_cell(0, 1'b0, 1'b1);
    endfunction

    function automatic void predict_item(cmd_item_t c);
        if (c.operation == OP_LOAD)
            blk_map[c.row * GRID_COLS + c.col] = c.blocked;
        else
            predict_search(c);
    endfunction

    // drive one item and hold it until accepted; valid stays up when the next follows at once
    task automatic send_item(cmd_item_t c, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_item(c);
        if (c.operation == OP_SEARCH)
            searches_sent++;
        else
            loads_sent++;
    endtask

    task automatic load_cell(int r, int c, bit b);
        cmd_item_t x;
        x = '0;
        x.operation = OP_LOAD;
        x.row = 3'(r);
        x.col = 3'(c);
        x.blocked = b;
        x.goal_row = 3'($urandom);
        x.goal_col = 3'($urandom);
        send_item(x, 1'b1);
    endtask

    task automatic search_path(int sr, int sc, int gr, int gc);
        cmd_item_t x;
        x = '0;
        x.operation = OP_SEARCH;
        x.row = 3'(sr);
        x.col = 3'(sc);
        x.goal_row = 3'(gr);
        x.goal_col = 3'(gc);
        x.blocked = 1'($urandom);
        send_item(x, 1'b1);
    endtask

    task automatic clear_grid();
        for (int i = 0; i < NCELLS; i++)
            if (blk_map[i])
                load_cell(i / GRID_COLS, i % GRID_COLS, 1'b0);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall per item, with stretches of none
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = rx_idle_off ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                hold = 0;
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // checker and watchdog sample on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_result(res);
            if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired, %0d items still expected", sb.pending_cells.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int pick, n_obst;
        foreach (blk_map[i])
            blk_map[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, start equals goal, blocked goal and start, walled off goal
        search_path(0, 0, 7, 7);
        search_path(7, 7, 0, 0);
        search_path(3, 4, 3, 4);
        search_path(0, 7, 7, 0);
        load_cell(7, 7, 1'b1);
        search_path(0, 0, 7, 7);
        search_path(7, 7, 7, 7);
        search_path(7, 7, 5, 5);
        load_cell(6, 6, 1'b1);
        load_cell(6, 7, 1'b1);
        load_cell(7, 6, 1'b1);
        load_cell(7, 7, 1'b0);
        search_path(0, 0, 7, 7);
        // wall with a gap forces a detour
        for (int r = 0; r < 7; r++)
            load_cell(r, 4, 1'b1);
        search_path(0, 0, 0, 7);
        search_path(0, 7, 5, 0);
        // the sender pauses until every expected item has come
        wait_drained();
        search_path(2, 1, 6, 5);
        clear_grid();

        // random: mostly sparse obstacles, searches with random ends
        while (loads_sent + searches_sent < 430)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                search_path($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 7), $urandom_range(0, 7));
            end
            else if (pick < 9)
            begin
                load_cell($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 3) == 0);
            end
            else
            begin
                // new obstacle field, sometimes dense; receiver stalls are switched off at random
                clear_grid();
                n_obst = $urandom_range(0, 30);
                for (int i = 0; i < n_obst; i++)
                    load_cell($urandom_range(0, 7), $urandom_range(0, 7), 1'b1);
                rx_idle_off = $urandom_range(0, 1);
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("covered %0d loads and %0d searches, %0d path items checked",
                 loads_sent, searches_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending_cells.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
